// ----- hdl/lfl_pkg.sv -----
// Shared types, token codes and keyword tables for the logic formula lexer.
`default_nettype none
package lfl_pkg;

    localparam int unsigned POSITION_BITS_DEF = 16;
    localparam int unsigned KEYWORD_MAX_LEN   = 10;
    localparam int unsigned KW_NUM            = 7;

    localparam logic [3:0] TK_LPAREN   = 4'd0;
    localparam logic [3:0] TK_RPAREN   = 4'd1;
    localparam logic [3:0] TK_VARIABLE = 4'd2;
    localparam logic [3:0] TK_TRUE     = 4'd3;
    localparam logic [3:0] TK_EOF      = 4'd10;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_CHAR    = 2'd1;
    localparam logic [1:0] ERR_KEYWORD = 2'd2;

    // keyword text, right-justified
    localparam logic [79:0] KW_STR [KW_NUM] = '{
        80'("TRUE"), 80'("FALSE"), 80'("NOT"), 80'("AND"),
        80'("OR"), 80'("IMPLIES"), 80'("EQUIVALENT")
    };
    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd4, 4'd5, 4'd3, 4'd3, 4'd2, 4'd7, 4'd10
    };

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_source;
    } char_beat_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] start_offset;
        logic [15:0] column;
        logic [15:0] line_number;
        logic [15:0] token_length;
        logic [1:0]  error_kind;
        logic [7:0]  bad_char;
        logic        last_result;
    } tok_beat_t;

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] i);
        logic [79:0] s;
        logic [3:0]  l;
        logic [6:0]  sh;
        s  = KW_STR[k];
        l  = KW_LEN[k];
        sh = {(l - 4'd1 - i), 3'b000};
        kw_char = (i < l) ? s[sh +: 8] : 8'h00;
    endfunction

    // narrow the live keyword set by the byte at word offset wlen
    function automatic logic [6:0] kw_extend(input logic [6:0] mask, input logic [3:0] wlen,
                                             input logic [7:0] c);
        logic [6:0] keep;
        keep = '0;
        for (int k = 0; k < KW_NUM; k++)
        begin
            if (wlen < 4'(KEYWORD_MAX_LEN) && wlen < KW_LEN[k] && kw_char(3'(k), wlen) == c)
            begin
                keep[k] = 1'b1;
            end
        end
        kw_extend = mask & keep;
    endfunction

    // {found, token kind}
    function automatic logic [4:0] kw_hit(input logic [6:0] mask, input logic [3:0] wlen);
        logic [4:0] r;
        r = '0;
        for (int k = KW_NUM - 1; k >= 0; k--)
        begin
            if (mask[k] && KW_LEN[k] == wlen)
            begin
                r = {1'b1, TK_TRUE + 4'(k)};
            end
        end
        kw_hit = r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/logic_formula_lexer_unit.sv -----
// Logic formula lexer: source bytes in, tokens with position information out.
//
// Channels: char_valid/char_ready/char_beat takes one source byte per beat, with
// end_of_source on the last byte of a text. tok_valid/tok_ready/tok_beat gives
// token beats, last_result high on the final beat of a text (eof or error).
// Each byte is lexed in the cycle it is accepted; its zero to three tokens sit
// in a three-entry result bank and are shown from the next cycle, one per beat.
// A byte is taken whenever the bank is empty or its final token leaves in the
// same cycle, so bytes yielding at most one token stream at one per cycle while
// tok_ready stays high; a byte yielding more tokens holds off the next byte.
// When tok_ready is low the bank holds and char_ready drops until it drains.
// After an error, bytes are taken and dropped until end_of_source.
// Reset (rst_n low, asynchronous) empties the bank and returns the lexer to
// the start of a source: offset 0, line 1, no word pending.
`default_nettype none
module logic_formula_lexer_unit #(
    parameter int unsigned POSITION_BITS = lfl_pkg::POSITION_BITS_DEF
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       char_valid,
    output logic                      char_ready,
    input  wire lfl_pkg::char_beat_t  char_beat,
    output logic                      tok_valid,
    input  wire                       tok_ready,
    output lfl_pkg::tok_beat_t        tok_beat
);
    import lfl_pkg::*;

    localparam int unsigned PB = POSITION_BITS;
    localparam int unsigned WB = (PB > 16) ? PB : 16;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    logic          in_word_reg, in_word_next;
    logic [6:0]    mask_reg, mask_next;
    logic [3:0]    wlen_reg, wlen_next;
    logic [PB-1:0] pos_reg, pos_next;
    logic [PB-1:0] tstart_reg, tstart_next;
    logic [PB-1:0] lnl_reg, lnl_next;
    logic [15:0]   line_reg, line_next;
    logic          disc_reg, disc_next;

    tok_beat_t     slot_reg [3];
    tok_beat_t     slot_next [3];
    logic [1:0]    cnt_reg, cnt_next;
    logic [1:0]    idx_reg;

    logic          char_acc, tok_take, last_take;
    logic [7:0]    cb;
    logic          eos, alpha, stop, restart;
    logic [4:0]    hit;
    logic [PB-1:0] pos_inc;

    function automatic logic [15:0] fit16(input logic [PB-1:0] v);
        logic [WB-1:0] w;
        w = WB'(v);
        fit16 = w[15:0];
    endfunction

    function automatic tok_beat_t mk(input logic [3:0] kind, input logic [PB-1:0] start,
                                     input logic [15:0] len, input logic [1:0] err,
                                     input logic [7:0] bad, input logic last,
                                     input logic [PB-1:0] lnl, input logic [15:0] line);
        tok_beat_t t;
        logic [WB-1:0] d;
        d = WB'(start) - WB'(lnl);
        t.token_kind   = kind;
        t.start_offset = fit16(start);
        t.column       = d[15:0];
        t.line_number  = line;
        t.token_length = len;
        t.error_kind   = err;
        t.bad_char     = bad;
        t.last_result  = last;
        mk = t;
    endfunction

    assign tok_valid = (cnt_reg != 2'd0);
    assign tok_beat  = slot_reg[idx_reg];
    assign tok_take  = tok_valid && tok_ready;
    assign last_take = tok_take && (idx_reg == cnt_reg - 2'd1);
    assign char_ready = (cnt_reg == 2'd0) || last_take;
    assign char_acc  = char_valid && char_ready;

    assign cb      = char_beat.char_byte;
    assign eos     = char_beat.end_of_source;
    assign alpha   = (cb inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    assign pos_inc = pos_reg + PB'(1);

    always_comb
    begin
        in_word_next = in_word_reg;
        mask_next    = mask_reg;
        wlen_next    = wlen_reg;
        pos_next     = pos_reg;
        tstart_next  = tstart_reg;
        lnl_next     = lnl_reg;
        line_next    = line_reg;
        disc_next    = disc_reg;
        for (int s = 0; s < 3; s++)
        begin
            slot_next[s] = '0;
        end
        cnt_next = 2'd0;
        stop     = 1'b0;
        restart  = 1'b0;
        hit      = '0;

        if (disc_reg)
        begin
            restart = eos;
        end
        else
        begin
            if (in_word_reg && !alpha)
            begin
                in_word_next = 1'b0;
                hit = kw_hit(mask_reg, wlen_reg);
                if (hit[4])
                begin
                    slot_next[cnt_next] = mk(hit[3:0], tstart_reg, fit16(pos_reg - tstart_reg),
                                             ERR_NONE, 8'h00, 1'b0, lnl_next, line_next);
                end
                else
                begin
                    slot_next[cnt_next] = mk(TK_LPAREN, tstart_reg, fit16(pos_reg - tstart_reg),
                                             ERR_KEYWORD, 8'h00, 1'b1, lnl_next, line_next);
                    stop      = 1'b1;
                    restart   = eos;
                    disc_next = !eos;
                end
                cnt_next = cnt_next + 2'd1;
            end

            if (!stop)
            begin
                if (in_word_next)
                begin
                    mask_next = kw_extend(mask_reg, wlen_reg, cb);
                    wlen_next = (wlen_reg != 4'd15) ? wlen_reg + 4'd1 : wlen_reg;
                end
                else if (cb inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})
                begin
                    if (cb == CH_LF)
                    begin
                        lnl_next  = pos_reg;
                        line_next = (line_reg != 16'hFFFF) ? line_reg + 16'd1 : line_reg;
                    end
                end
                else if (cb inside {CH_LPAREN, CH_RPAREN, "P", "S", "Q"})
                begin
                    tstart_next = pos_reg;
                    slot_next[cnt_next] = mk((cb == CH_LPAREN) ? TK_LPAREN :
                                             (cb == CH_RPAREN) ? TK_RPAREN : TK_VARIABLE,
                                             pos_reg, 16'd1, ERR_NONE, 8'h00, 1'b0,
                                             lnl_next, line_next);
                    cnt_next = cnt_next + 2'd1;
                end
                else if (alpha)
                begin
                    in_word_next = 1'b1;
                    tstart_next  = pos_reg;
                    mask_next    = kw_extend(7'h7F, 4'd0, cb);
                    wlen_next    = 4'd1;
                end
                else
                begin
                    tstart_next = pos_reg;
                    slot_next[cnt_next] = mk(TK_LPAREN, pos_reg, 16'd1, ERR_CHAR, cb, 1'b1,
                                             lnl_next, line_next);
                    cnt_next  = cnt_next + 2'd1;
                    stop      = 1'b1;
                    restart   = eos;
                    disc_next = !eos;
                end
            end

            if (!stop)
            begin
                pos_next = pos_inc;
                if (eos)
                begin
                    restart = 1'b1;
                    hit = kw_hit(mask_next, wlen_next);
                    if (in_word_next)
                    begin
                        slot_next[cnt_next] = mk(hit[4] ? hit[3:0] : TK_LPAREN, tstart_next,
                                                 fit16(pos_inc - tstart_next),
                                                 hit[4] ? ERR_NONE : ERR_KEYWORD, 8'h00,
                                                 !hit[4], lnl_next, line_next);
                        cnt_next = cnt_next + 2'd1;
                    end
                    if (!in_word_next || hit[4])
                    begin
                        slot_next[cnt_next] = mk(TK_EOF, pos_inc, 16'd0, ERR_NONE, 8'h00, 1'b1,
                                                 lnl_next, line_next);
                        cnt_next = cnt_next + 2'd1;
                    end
                end
            end
        end

        if (restart)
        begin
            in_word_next = 1'b0;
            mask_next    = 7'h7F;
            wlen_next    = 4'd0;
            pos_next     = '0;
            tstart_next  = '0;
            lnl_next     = '0;
            line_next    = 16'd1;
            disc_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg <= 1'b0;
            mask_reg    <= 7'h7F;
            wlen_reg    <= 4'd0;
            pos_reg     <= '0;
            tstart_reg  <= '0;
            lnl_reg     <= '0;
            line_reg    <= 16'd1;
            disc_reg    <= 1'b0;
            cnt_reg     <= 2'd0;
            idx_reg     <= 2'd0;
        end
        else if (char_acc)
        begin
            in_word_reg <= in_word_next;
            mask_reg    <= mask_next;
            wlen_reg    <= wlen_next;
            pos_reg     <= pos_next;
            tstart_reg  <= tstart_next;
            lnl_reg     <= lnl_next;
            line_reg    <= line_next;
            disc_reg    <= disc_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= 2'd0;
        end
        else if (last_take)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else if (tok_take)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_acc)
        begin
            for (int s = 0; s < 3; s++)
            begin
                slot_reg[s] <= slot_next[s];
            end
        end
    end

    a_idx_in_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 2'd0) |-> (idx_reg < cnt_reg))
        else $error("result index beyond bank fill");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> char_ready)
        else $error("input stalled with empty result bank");

    a_discard_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        disc_reg |-> !in_word_reg)
        else $error("word pending while discarding");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != 16'd0)
        else $error("line count reached zero");

endmodule
`default_nettype wire
